@@ rtl/core/smsi_pkg.sv @@
`default_nettype none
package smsi_pkg;

  localparam int DEF_N_CORES          = 4;
  localparam int DEF_SETS             = 64;
  localparam int DEF_WAYS             = 4;
  localparam int DEF_LINE_OFFSET_BITS = 6;
  localparam int DEF_ADDRESS_BITS     = 48;

  localparam int CORE_ID_W = 2;
  localparam int ADDR_IN_W = 48;
  localparam int ST_W      = 2;
  localparam int CNT_W     = 2;

  typedef logic [ST_W-1:0] line_st_t;

  localparam line_st_t ST_I = 2'd0;
  localparam line_st_t ST_S = 2'd1;
  localparam line_st_t ST_M = 2'd2;

  localparam logic REQ_RD = 1'b0;
  localparam logic REQ_WR = 1'b1;

endpackage
`default_nettype wire

@@ rtl/core/smsi_ram.sv @@
`default_nettype none
module smsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/snoopy_msi_coherence_top.sv @@
// Snoopy MSI coherence tracker for N_CORES private set-associative caches.
// Input channel (in_valid / in_stall): one access per item, giving core_id,
// byte address and req_type (0 read, 1 write).
// Output channel (out_valid / out_stall): one result per access: hit,
// prior_state, evicted, peers_invalidated and peers_downgraded.
// Each core's tags, MSI states and LRU ages sit in one RAM row per set.
// An access reads the set from every core's RAM in its accept cycle and
// writes the updated rows back in the next cycle, when the result is
// registered. out_valid is set at the end of S_RUN, together with the
// result registers. No new item is taken while an access is in S_RUN, so
// the block cannot take an item before the last one is through, bounded by
// the read-modify-write of the set RAMs.
// After reset the block sweeps all SETS rows, clearing them to invalid,
// so in_stall stays high during the sweep; no item is taken meanwhile.
// The result register holds one item; while it is full and stalled, in_stall
// is high and no further access is taken.
`default_nettype none
module snoopy_msi_coherence_top #(
  parameter int N_CORES          = smsi_pkg::DEF_N_CORES,
  parameter int SETS             = smsi_pkg::DEF_SETS,
  parameter int WAYS             = smsi_pkg::DEF_WAYS,
  parameter int LINE_OFFSET_BITS = smsi_pkg::DEF_LINE_OFFSET_BITS,
  parameter int ADDRESS_BITS     = smsi_pkg::DEF_ADDRESS_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [smsi_pkg::CORE_ID_W-1:0]  core_id,
  input  wire logic [smsi_pkg::ADDR_IN_W-1:0]  address,
  input  wire logic                            req_type,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 hit,
  output logic [smsi_pkg::ST_W-1:0]            prior_state,
  output logic                                 evicted,
  output logic [smsi_pkg::CNT_W-1:0]           peers_invalidated,
  output logic [smsi_pkg::CNT_W-1:0]           peers_downgraded
);
  import smsi_pkg::*;

  localparam int LOG_SETS = $clog2(SETS);
  localparam int SET_W    = (SETS > 1) ? LOG_SETS : 1;
  localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W    = ADDRESS_BITS - LINE_OFFSET_BITS - LOG_SETS;
  localparam int WAY_W    = TAG_W + ST_W + AGE_W;
  localparam int ROW_W    = WAYS * WAY_W;
  localparam logic [63:0] AMASK = (ADDRESS_BITS >= 64) ? {64{1'b1}}
                                  : ((64'd1 << ADDRESS_BITS) - 64'd1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  logic [1:0]           state;
  logic [SET_W-1:0]     clr_cnt;
  logic [CORE_ID_W-1:0] req_core;
  logic [TAG_W-1:0]     req_tag;
  logic [SET_W-1:0]     req_set;
  logic                 req_wr;
  logic                 req_ok;

  logic [63:0]          block;
  logic [SET_W-1:0]     set_in;
  logic [TAG_W-1:0]     tag_in;
  logic                 in_acc;

  logic [ROW_W-1:0]     rrow [N_CORES];
  logic [ROW_W-1:0]     wrow [N_CORES];
  logic                 ram_we;
  logic [SET_W-1:0]     ram_waddr;

  logic [TAG_W-1:0]     tg  [N_CORES][WAYS];
  line_st_t             st  [N_CORES][WAYS];
  logic [AGE_W-1:0]     ag  [N_CORES][WAYS];
  logic [TAG_W-1:0]     ntg [N_CORES][WAYS];
  line_st_t             nst [N_CORES][WAYS];
  logic [AGE_W-1:0]     nag [N_CORES][WAYS];
  logic                 fnd [N_CORES];
  logic [AGE_W-1:0]     fidx [N_CORES];

  logic                 r_hit;
  line_st_t             r_prior;
  logic                 r_ev;
  logic [4:0]           inv_cnt;
  logic [4:0]           down_cnt;

  assign block  = (64'(address) & AMASK) >> LINE_OFFSET_BITS;
  assign set_in = (SETS > 1) ? SET_W'(block) : '0;
  assign tag_in = TAG_W'(block >> LOG_SETS);

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign ram_we    = (state == S_CLEAR) || (state == S_RUN && req_ok);
  assign ram_waddr = (state == S_CLEAR) ? clr_cnt : req_set;

  for (genvar g = 0; g < N_CORES; g++) begin : g_core
    smsi_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ((state == S_CLEAR) ? '0 : wrow[g]),
      .raddr (set_in),
      .rdata (rrow[g])
    );
  end

  always_comb begin
    logic [AGE_W-1:0] old;
    logic [AGE_W-1:0] best;
    logic [AGE_W-1:0] slot;
    logic             has_inv;
    logic             is_req;
    old      = '0;
    best     = '0;
    slot     = '0;
    has_inv  = 1'b0;
    is_req   = 1'b0;
    r_hit    = 1'b0;
    r_prior  = ST_I;
    r_ev     = 1'b0;
    inv_cnt  = '0;
    down_cnt = '0;
    for (int p = 0; p < N_CORES; p++) begin
      fnd[p]  = 1'b0;
      fidx[p] = '0;
      for (int w = 0; w < WAYS; w++) begin
        tg[p][w] = rrow[p][w*WAY_W + AGE_W + ST_W +: TAG_W];
        st[p][w] = rrow[p][w*WAY_W + AGE_W +: ST_W];
        ag[p][w] = rrow[p][w*WAY_W +: AGE_W];
        ntg[p][w] = tg[p][w];
        nst[p][w] = st[p][w];
        nag[p][w] = ag[p][w];
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (st[p][w] != ST_I && tg[p][w] == req_tag) begin
          fnd[p]  = 1'b1;
          fidx[p] = AGE_W'(w);
        end
      end
      if (32'(req_core) == p && fnd[p]) begin
        r_prior = st[p][fidx[p]];
      end
    end
    r_hit = req_ok && ((req_wr == REQ_WR) ? (r_prior == ST_M) : (r_prior != ST_I));

    for (int p = 0; p < N_CORES; p++) begin
      is_req = (32'(req_core) == p);
      if (is_req) begin
        if (r_hit || (req_wr == REQ_WR && r_prior == ST_S)) begin
          old = ag[p][fidx[p]];
          for (int v = 0; v < WAYS; v++) begin
            if (AGE_W'(v) != fidx[p] && st[p][v] != ST_I && ag[p][v] < old) begin
              nag[p][v] = ag[p][v] + 1'b1;
            end
          end
          nag[p][fidx[p]] = '0;
          if (req_wr == REQ_WR) begin
            nst[p][fidx[p]] = ST_M;
          end
        end else begin
          has_inv = 1'b0;
          slot    = '0;
          for (int w = WAYS - 1; w >= 0; w--) begin
            if (st[p][w] == ST_I) begin
              has_inv = 1'b1;
              slot    = AGE_W'(w);
            end
          end
          if (!has_inv) begin
            best = '0;
            for (int w = 0; w < WAYS; w++) begin
              if (ag[p][w] >= best) begin
                best = ag[p][w];
                slot = AGE_W'(w);
              end
            end
            r_ev = 1'b1;
            old  = nag[p][slot];
            nst[p][slot] = ST_I;
            nag[p][slot] = '0;
            for (int v = 0; v < WAYS; v++) begin
              if (nst[p][v] != ST_I && nag[p][v] > old) begin
                nag[p][v] = nag[p][v] - 1'b1;
              end
            end
          end
          for (int v = 0; v < WAYS; v++) begin
            if (nst[p][v] != ST_I) begin
              nag[p][v] = nag[p][v] + 1'b1;
            end
          end
          ntg[p][slot] = req_tag;
          nst[p][slot] = (req_wr == REQ_WR) ? ST_M : ST_S;
          nag[p][slot] = '0;
        end
      end else if (!r_hit && fnd[p]) begin
        if (req_wr == REQ_RD) begin
          if (st[p][fidx[p]] == ST_M) begin
            nst[p][fidx[p]] = ST_S;
            down_cnt = down_cnt + 5'd1;
          end
        end else begin
          old = ag[p][fidx[p]];
          nst[p][fidx[p]] = ST_I;
          nag[p][fidx[p]] = '0;
          for (int v = 0; v < WAYS; v++) begin
            if (nst[p][v] != ST_I && nag[p][v] > old) begin
              nag[p][v] = nag[p][v] - 1'b1;
            end
          end
          inv_cnt = inv_cnt + 5'd1;
        end
      end
    end

    for (int p = 0; p < N_CORES; p++) begin
      for (int w = 0; w < WAYS; w++) begin
        wrow[p][w*WAY_W +: WAY_W] = {ntg[p][w], nst[p][w], nag[p][w]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == SET_W'(SETS - 1)) begin
            state <= S_IDLE;
          end
          clr_cnt <= clr_cnt + 1'b1;
        end
        S_IDLE: begin
          if (in_acc) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_core <= core_id;
      req_tag  <= tag_in;
      req_set  <= set_in;
      req_wr   <= req_type;
      req_ok   <= (32'(core_id) < N_CORES);
    end
    if (state == S_RUN) begin
      hit               <= r_hit;
      prior_state       <= req_ok ? r_prior : ST_I;
      evicted           <= req_ok && r_ev;
      peers_invalidated <= !req_ok ? '0 : (inv_cnt > 5'd3) ? 2'd3 : CNT_W'(inv_cnt);
      peers_downgraded  <= !req_ok ? '0 : (down_cnt > 5'd3) ? 2'd3 : CNT_W'(down_cnt);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/snoopy_msi_coherence_chk.sv @@
`default_nettype none
module snoopy_msi_coherence_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       hit,
  input wire logic [1:0] prior_state,
  input wire logic       evicted,
  input wire logic [1:0] peers_invalidated,
  input wire logic [1:0] peers_downgraded
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken back to back");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("result missing two cycles after accept");

  a_hit_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> prior_state != 2'd0 && !evicted
                         && peers_invalidated == 2'd0 && peers_downgraded == 2'd0)
    else $error("hit with snoop or fill side effects");

  a_evict_on_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !hit && prior_state == 2'd0)
    else $error("eviction without fill");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("not empty after reset");

endmodule

bind snoopy_msi_coherence_top snoopy_msi_coherence_chk u_chk (.*);
`default_nettype wire
